FILE: hw/rtl/etl_pkg.sv
// Shared types, token codes and character-class helpers for the expression lexer.
// Used by expression_token_lexer_core and tb_top; depends on nothing else.
package etl_pkg;

  localparam int unsigned MAX_CHARS_DEF = 4096;

  // token kinds
  localparam logic [2:0] K_IDENT = 3'd0;
  localparam logic [2:0] K_LIT   = 3'd1;
  localparam logic [2:0] K_OP    = 3'd2;
  localparam logic [2:0] K_OPEN  = 3'd3;
  localparam logic [2:0] K_CLOSE = 3'd4;
  localparam logic [2:0] K_ERR   = 3'd5;
  localparam logic [2:0] K_END   = 3'd6;

  // operator codes
  localparam logic [3:0] OP_ADD    = 4'd0;
  localparam logic [3:0] OP_SUB    = 4'd1;
  localparam logic [3:0] OP_MUL    = 4'd2;
  localparam logic [3:0] OP_DIV    = 4'd3;
  localparam logic [3:0] OP_ASSIGN = 4'd8;

  // numeric bases for the accumulator
  localparam logic [1:0] B_2  = 2'd0;
  localparam logic [1:0] B_8  = 2'd1;
  localparam logic [1:0] B_10 = 2'd2;
  localparam logic [1:0] B_16 = 2'd3;

  typedef enum logic [9:0] {
    M_IDLE   = 10'b0000000001,
    M_IDENT  = 10'b0000000010,
    M_ZERO   = 10'b0000000100,
    M_DEC    = 10'b0000001000,
    M_OCT    = 10'b0000010000,
    M_HEXPFX = 10'b0000100000,
    M_HEX    = 10'b0001000000,
    M_BINPFX = 10'b0010000000,
    M_BIN    = 10'b0100000000,
    M_OP     = 10'b1000000000
  } mode_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [63:0] value;
    logic [11:0] start;
    logic [12:0] length;
    logic [7:0]  bad;
    logic        last;
  } tok_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_digit(c) || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    if (is_digit(c)) v = c - 8'h30;
    else if ((c >= "a") && (c <= "f")) v = c - 8'h57;
    else v = c - 8'h37;
    return v[3:0];
  endfunction

  // expected keyword characters at a given index
  function automatic logic kw_true_at(input logic [2:0] i, input logic [7:0] c);
    logic r;
    case (i)
      3'd0: r = (c == "t");
      3'd1: r = (c == "r");
      3'd2: r = (c == "u");
      3'd3: r = (c == "e");
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic kw_false_at(input logic [2:0] i, input logic [7:0] c);
    logic r;
    case (i)
      3'd0: r = (c == "f");
      3'd1: r = (c == "a");
      3'd2: r = (c == "l");
      3'd3: r = (c == "s");
      3'd4: r = (c == "e");
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  // acc*base+d with saturation; result bit 64 is the overflow flag
  function automatic logic [64:0] accumulate(input logic [63:0] acc, input logic ovf,
                                             input logic [1:0] base, input logic [3:0] d);
    logic [68:0] prod;
    logic [68:0] sum;
    case (base)
      B_2:     prod = {4'd0, acc, 1'b0};
      B_8:     prod = {2'd0, acc, 3'd0};
      B_10:    prod = {2'd0, acc, 3'd0} + {4'd0, acc, 1'b0};
      default: prod = {1'b0, acc, 4'd0};
    endcase
    sum = prod + {65'd0, d};
    if (ovf || (sum[68:64] != 5'd0)) return {1'b1, {64{1'b1}}};
    return {1'b0, sum[63:0]};
  endfunction

  function automatic tok_t mk_tok(input logic [2:0] kind, input logic [63:0] value,
                                  input logic [11:0] start, input logic [12:0] length,
                                  input logic [7:0] bad);
    tok_t t;
    t.kind = kind;
    t.value = value;
    t.start = start;
    t.length = length;
    t.bad = bad;
    t.last = 1'b0;
    return t;
  endfunction

endpackage

FILE: hw/rtl/expression_token_lexer_core.sv
// Streaming tokenizer for arithmetic expressions, one character per request.
// Depends on etl_pkg (types, codes, helpers).
//
//  channel | dir | handshake            | payload
//  in_     | in  | in_tvalid/in_tready  | tdata char_byte, tlast end_mark
//  out_    | out | out_tvalid/out_tready| tdata value/start/length/bad,
//          |     |                      | tuser token_kind, tlast last_result
//
// One input request is taken per cycle. Its tokens (up to two) are written
// into a four-entry result queue at the accepting edge, and leave one per
// cycle from the next cycle on. in_tready drops while the queue holds more
// than two tokens. The rate is one request a cycle until two-token requests
// outpace the one-per-cycle drain, or the output stalls.
// rst_n (synchronous) returns the scanner to idle and empties the queue.
module expression_token_lexer_core #(
  parameter int unsigned MAX_CHARS = etl_pkg::MAX_CHARS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] char_byte
  input  logic         in_tlast,   // end_mark
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata,  // [63:0] token_value, [75:64] token_start,
                                   // [88:76] token_length, [96:89] bad_char, zero fill
  output logic [2:0]   out_tuser,  // [2:0] token_kind
  output logic         out_tlast   // last_result
);
  import etl_pkg::*;

  localparam int POS_W = $clog2(MAX_CHARS);
  localparam int LEN_W = $clog2(MAX_CHARS + 1);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_CHARS - 1);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_CHARS);

  // scanner state
  mode_t             mode_r, mode_nxt;
  logic [63:0]       acc_r, acc_nxt;
  logic              ovf_r, ovf_nxt;
  logic [POS_W-1:0]  start_r, start_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [POS_W-1:0]  cpos_r, cpos_nxt;
  logic [1:0]        kw_r, kw_nxt;
  logic [1:0]        op_r, op_nxt;
  logic              err_r, err_nxt;
  logic              hexx_r, hexx_nxt;  // 1: prefix was 'X'

  // result queue
  tok_t              q_mem [4];
  logic [1:0]        wr_ptr_r, rd_ptr_r;
  logic [2:0]        cnt_r;

  tok_t              res0, res1;
  logic [1:0]        n_c;
  logic              in_acc, out_acc;

  assign in_tready = (cnt_r <= 3'd2);
  assign in_acc    = in_tvalid && in_tready;
  assign out_acc   = out_tvalid && out_tready;

  function automatic logic [11:0] pos12(input logic [POS_W-1:0] p);
    return 12'(32'(p));
  endfunction

  function automatic logic [12:0] len13(input logic [LEN_W-1:0] l);
    return 13'(32'(l));
  endfunction

  // tokenize one request
  always_comb begin
    logic [7:0]       c;
    logic [POS_W-1:0] pos;
    logic             flush_now, start_now, letter_err;
    logic [64:0]      ar;
    tok_t             t;
    c = in_tdata;
    pos = cpos_r;
    flush_now = 1'b0;
    start_now = 1'b0;
    letter_err = 1'b0;
    ar = '0;
    t = '0;
    res0 = '0;
    res1 = '0;
    n_c = 2'd0;
    mode_nxt = mode_r;
    acc_nxt = acc_r;
    ovf_nxt = ovf_r;
    start_nxt = start_r;
    len_nxt = len_r;
    cpos_nxt = cpos_r;
    kw_nxt = kw_r;
    op_nxt = op_r;
    err_nxt = err_r;
    hexx_nxt = hexx_r;

    if (in_acc) begin
      if (in_tlast) begin
        flush_now = !err_r;
      end else if (!err_r) begin
        // advance the scanner on this character
        case (mode_r)
          M_IDENT: begin
            if (is_alpha(c) || is_digit(c) || c == "." || c == "_" || c == "/") begin
              if (!((len_r < LEN_W'(4)) && kw_true_at(len_r[2:0], c))) kw_nxt[0] = 1'b0;
              if (!((len_r < LEN_W'(5)) && kw_false_at(len_r[2:0], c))) kw_nxt[1] = 1'b0;
              if (len_r < LEN_MAX) len_nxt = len_r + 1'b1;
            end else begin
              flush_now = 1'b1;
              start_now = 1'b1;
            end
          end
          M_ZERO: begin
            if (c == "x" || c == "X") begin
              mode_nxt = M_HEXPFX;
              hexx_nxt = (c == "X");
              if (len_r < LEN_MAX) len_nxt = len_r + 1'b1;
            end else if (c == "b") begin
              mode_nxt = M_BINPFX;
              if (len_r < LEN_MAX) len_nxt = len_r + 1'b1;
            end else if (c >= "0" && c <= "7") begin
              mode_nxt = M_OCT;
              ar = accumulate(acc_r, ovf_r, B_8, c[3:0]);
              {ovf_nxt, acc_nxt} = ar;
              if (len_r < LEN_MAX) len_nxt = len_r + 1'b1;
            end else begin
              flush_now = 1'b1;
              letter_err = is_alpha(c);
              start_now = !is_alpha(c);
            end
          end
          M_DEC, M_OCT, M_HEX, M_BINPFX, M_BIN: begin
            if ((mode_r == M_DEC && is_digit(c)) ||
                (mode_r == M_OCT && c >= "0" && c <= "7") ||
                (mode_r == M_HEX && is_hex(c)) ||
                ((mode_r == M_BINPFX || mode_r == M_BIN) && (c == "0" || c == "1"))) begin
              case (mode_r)
                M_DEC:   ar = accumulate(acc_r, ovf_r, B_10, hex_val(c));
                M_OCT:   ar = accumulate(acc_r, ovf_r, B_8, hex_val(c));
                M_HEX:   ar = accumulate(acc_r, ovf_r, B_16, hex_val(c));
                default: ar = accumulate(acc_r, ovf_r, B_2, hex_val(c));
              endcase
              {ovf_nxt, acc_nxt} = ar;
              if (mode_r == M_BINPFX) mode_nxt = M_BIN;
              if (len_r < LEN_MAX) len_nxt = len_r + 1'b1;
            end else begin
              flush_now = 1'b1;
              letter_err = is_alpha(c);
              start_now = !is_alpha(c);
            end
          end
          M_HEXPFX: begin
            if (is_hex(c)) begin
              mode_nxt = M_HEX;
              acc_nxt = {60'd0, hex_val(c)};
              if (len_r < LEN_MAX) len_nxt = len_r + 1'b1;
            end else begin
              flush_now = 1'b1;
            end
          end
          M_OP: begin
            if (c == "=") begin
              t = mk_tok(K_OP, {62'd0, op_r} + 64'd4, pos12(start_r), 13'd2, 8'd0);
              res0 = t;
              n_c = 2'd1;
              mode_nxt = M_IDLE;
              acc_nxt = '0;
              ovf_nxt = 1'b0;
              len_nxt = '0;
              kw_nxt = 2'b11;
              op_nxt = '0;
            end else begin
              flush_now = 1'b1;
              start_now = 1'b1;
            end
          end
          default: start_now = 1'b1;
        endcase
      end

      // report the held token
      if (flush_now) begin
        case (mode_r)
          M_IDENT: begin
            if (len_r == LEN_W'(4) && kw_r[0])
              t = mk_tok(K_LIT, 64'd1, pos12(start_r), len13(len_r), 8'd0);
            else if (len_r == LEN_W'(5) && kw_r[1])
              t = mk_tok(K_LIT, 64'd0, pos12(start_r), len13(len_r), 8'd0);
            else
              t = mk_tok(K_IDENT, 64'd0, pos12(start_r), len13(len_r), 8'd0);
            res0 = t;
            n_c = 2'd1;
          end
          M_ZERO, M_DEC, M_OCT, M_HEX, M_BINPFX, M_BIN: begin
            t = mk_tok(K_LIT, ovf_r ? {64{1'b1}} : acc_r, pos12(start_r), len13(len_r), 8'd0);
            res0 = t;
            n_c = 2'd1;
          end
          M_HEXPFX: begin
            res0 = mk_tok(K_LIT, 64'd0, pos12(start_r), 13'd1, 8'd0);
            res1 = mk_tok(K_ERR, 64'd0,
                          pos12((start_r == POS_MAX) ? '0 : start_r + 1'b1),
                          13'd1, hexx_r ? 8'h58 : 8'h78);
            n_c = 2'd2;
            err_nxt = 1'b1;
          end
          M_OP: begin
            res0 = mk_tok(K_OP, {62'd0, op_r}, pos12(start_r), 13'd1, 8'd0);
            n_c = 2'd1;
          end
          default: ;
        endcase
        mode_nxt = M_IDLE;
        acc_nxt = '0;
        ovf_nxt = 1'b0;
        len_nxt = '0;
        kw_nxt = 2'b11;
        op_nxt = '0;
      end

      // letter right after a number
      if (letter_err) begin
        t = mk_tok(K_ERR, 64'd0, pos12(pos), 13'd1, c);
        if (n_c == 2'd0) res0 = t; else res1 = t;
        n_c = n_c + 2'd1;
        err_nxt = 1'b1;
      end

      // open a new token on this character
      if (start_now) begin
        start_nxt = pos;
        len_nxt = LEN_W'(1);
        t = '0;
        if (is_alpha(c) || c == "." || c == "_") begin
          mode_nxt = M_IDENT;
          kw_nxt = {c == "f", c == "t"};
        end else if (is_digit(c)) begin
          mode_nxt = (c == "0") ? M_ZERO : M_DEC;
          acc_nxt = {60'd0, c[3:0]};
        end else if (c == "+" || c == "-" || c == "*" || c == "/") begin
          mode_nxt = M_OP;
          op_nxt = (c == "+") ? OP_ADD[1:0] : (c == "-") ? OP_SUB[1:0] :
                   (c == "*") ? OP_MUL[1:0] : OP_DIV[1:0];
        end else begin
          len_nxt = '0;
          if (c == "=") t = mk_tok(K_OP, 64'(OP_ASSIGN), pos12(pos), 13'd1, 8'd0);
          else if (c == "(") t = mk_tok(K_OPEN, 64'd0, pos12(pos), 13'd1, 8'd0);
          else if (c == ")") t = mk_tok(K_CLOSE, 64'd0, pos12(pos), 13'd1, 8'd0);
          else if (!(c == " " || c == 8'h0d || c == 8'h0a || c == 8'h09)) begin
            t = mk_tok(K_ERR, 64'd0, pos12(pos), 13'd1, c);
            err_nxt = 1'b1;
          end
          if (c != " " && c != 8'h0d && c != 8'h0a && c != 8'h09) begin
            if (n_c == 2'd0) res0 = t; else res1 = t;
            n_c = n_c + 2'd1;
          end
        end
      end

      if (in_tlast) begin
        // end marker, then back to reset state
        if (!err_nxt) begin
          t = mk_tok(K_END, 64'd0, pos12(pos), 13'd0, 8'd0);
          if (n_c == 2'd0) res0 = t; else res1 = t;
          n_c = n_c + 2'd1;
        end else if (err_r) begin
          res0 = mk_tok(K_END, 64'd0, pos12(pos), 13'd0, 8'd0);
          n_c = 2'd1;
        end
        mode_nxt = M_IDLE;
        acc_nxt = '0;
        ovf_nxt = 1'b0;
        start_nxt = '0;
        len_nxt = '0;
        cpos_nxt = '0;
        kw_nxt = 2'b11;
        op_nxt = '0;
        err_nxt = 1'b0;
        hexx_nxt = 1'b0;
      end else if (!err_r) begin
        cpos_nxt = (pos == POS_MAX) ? '0 : pos + 1'b1;
        if (err_nxt) begin
          mode_nxt = M_IDLE;
          acc_nxt = '0;
          ovf_nxt = 1'b0;
          len_nxt = '0;
          kw_nxt = 2'b11;
          op_nxt = '0;
        end
      end

      // mark the last token of this request
      if (n_c == 2'd1) res0.last = 1'b1;
      if (n_c == 2'd2) res1.last = 1'b1;
    end
  end

  // scanner registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      acc_r <= '0;
      ovf_r <= 1'b0;
      start_r <= '0;
      len_r <= '0;
      cpos_r <= '0;
      kw_r <= 2'b11;
      op_r <= '0;
      err_r <= 1'b0;
      hexx_r <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
      acc_r <= acc_nxt;
      ovf_r <= ovf_nxt;
      start_r <= start_nxt;
      len_r <= len_nxt;
      cpos_r <= cpos_nxt;
      kw_r <= kw_nxt;
      op_r <= op_nxt;
      err_r <= err_nxt;
      hexx_r <= hexx_nxt;
    end
  end

  // push tokens into the queue
  always_ff @(posedge clk) begin
    if (n_c != 2'd0) q_mem[wr_ptr_r] <= res0;
    if (n_c == 2'd2) q_mem[wr_ptr_r + 2'd1] <= res1;
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + n_c;
      if (out_acc) rd_ptr_r <= rd_ptr_r + 2'd1;
      cnt_r <= cnt_r + {1'b0, n_c} - {2'd0, out_acc};
    end
  end

  assign out_tvalid = (cnt_r != 3'd0);
  assign out_tuser  = q_mem[rd_ptr_r].kind;
  assign out_tlast  = q_mem[rd_ptr_r].last;
  assign out_tdata  = {7'd0, q_mem[rd_ptr_r].bad, q_mem[rd_ptr_r].length,
                       q_mem[rd_ptr_r].start, q_mem[rd_ptr_r].value};

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 3'd4)
    else $error("result queue overfilled");
  a_err_idle: assert property (@(posedge clk) disable iff (!rst_n)
    err_r |-> mode_r == M_IDLE)
    else $error("token held while error latched");
  a_end_reset: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_tlast |=> mode_r == M_IDLE && !err_r && cpos_r == '0)
    else $error("end request did not restore scanner");
  a_end_tok: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_tlast |-> n_c != 2'd0)
    else $error("end request produced no token");

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for expression_token_lexer_core: a lexer predictor,
// a queued stream driver and a checking monitor. Depends on etl_pkg and the core.
`timescale 1ns / 100ps

module tb_top;
  import etl_pkg::*;

  localparam int unsigned MAXC = 4096;

  // scanner modes of the predictor
  typedef enum int {
    S_IDLE, S_IDENT, S_ZERO, S_DEC, S_OCT, S_HEXPFX, S_HEX, S_BINPFX, S_BIN, S_OP
  } scan_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       eos;
  } char_req_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata = '0;
  logic         in_tlast = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [103:0] out_tdata;
  logic [2:0]   out_tuser;
  logic         out_tlast;

  expression_token_lexer_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  always #2 clk = ~clk;

  char_req_t pending_chars[$];
  tok_t      expected_tokens[$];
  int        errors = 0;
  int        tokens_seen = 0;
  bit        stim_done = 1'b0;
  bit        in_hs = 1'b0;

  // predictor state
  scan_e       lx_mode;
  logic [63:0] lx_acc;
  bit          lx_ovf;
  int unsigned lx_start, lx_len, lx_pos;
  bit [1:0]    lx_kw;
  int unsigned lx_op;
  bit          lx_err;
  logic [7:0]  lx_xch;
  tok_t        step_toks[$];

  function automatic bit c_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit c_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic int c_hexval(logic [7:0] c);
    if (c_digit(c)) return c - "0";
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return -1;
  endfunction

  function automatic void push_tok(logic [2:0] k, logic [63:0] v, int unsigned s,
                                   int unsigned l, logic [7:0] b);
    tok_t t;
    t.kind = k; t.value = v; t.start = s[11:0]; t.length = l[12:0];
    t.bad = b; t.last = 1'b0;
    step_toks.push_back(t);
  endfunction

  function automatic void clear_scan();
    lx_mode = S_IDLE; lx_acc = '0; lx_ovf = 0; lx_len = 0; lx_kw = 2'b11; lx_op = 0;
  endfunction

  function automatic void reset_scan();
    clear_scan();
    lx_start = 0; lx_pos = 0; lx_err = 0; lx_xch = "x";
  endfunction

  // saturating acc*base+d
  function automatic void add_digit(int unsigned base, int unsigned d);
    logic [71:0] wide;
    wide = {8'd0, lx_acc} * base + d;
    if (lx_ovf || wide[71:64] != 0) begin
      lx_ovf = 1; lx_acc = '1;
    end else begin
      lx_acc = wide[63:0];
    end
  endfunction

  function automatic void bump_len();
    if (lx_len < MAXC) lx_len++;
  endfunction

  // report the held token
  function automatic void flush_held();
    logic [63:0] lit;
    lit = lx_ovf ? '1 : lx_acc;
    case (lx_mode)
      S_IDENT: begin
        if (lx_len == 4 && lx_kw[0]) push_tok(K_LIT, 64'd1, lx_start, lx_len, 0);
        else if (lx_len == 5 && lx_kw[1]) push_tok(K_LIT, 64'd0, lx_start, lx_len, 0);
        else push_tok(K_IDENT, 0, lx_start, lx_len, 0);
      end
      S_ZERO, S_DEC, S_OCT, S_HEX, S_BINPFX, S_BIN:
        push_tok(K_LIT, lit, lx_start, lx_len, 0);
      S_HEXPFX: begin
        push_tok(K_LIT, 0, lx_start, 1, 0);
        push_tok(K_ERR, 0, (lx_start + 1) % MAXC, 1, lx_xch);
        lx_err = 1;
      end
      S_OP: push_tok(K_OP, lx_op, lx_start, 1, 0);
      default: ;
    endcase
    clear_scan();
  endfunction

  function automatic void begin_token(logic [7:0] c, int unsigned p);
    lx_start = p;
    lx_len = 1;
    if (c_alpha(c) || c == "." || c == "_") begin
      lx_mode = S_IDENT;
      lx_kw = {c == "f", c == "t"};
    end else if (c_digit(c)) begin
      lx_mode = (c == "0") ? S_ZERO : S_DEC;
      lx_acc = c - "0";
    end else if (c == "+" || c == "-" || c == "*" || c == "/") begin
      lx_mode = S_OP;
      lx_op = (c == "+") ? OP_ADD : (c == "-") ? OP_SUB : (c == "*") ? OP_MUL : OP_DIV;
    end else begin
      lx_len = 0;
      if (c == "=") push_tok(K_OP, OP_ASSIGN, p, 1, 0);
      else if (c == "(") push_tok(K_OPEN, 0, p, 1, 0);
      else if (c == ")") push_tok(K_CLOSE, 0, p, 1, 0);
      else if (c == " " || c == 8'h0d || c == 8'h0a || c == 8'h09) ;
      else begin
        push_tok(K_ERR, 0, p, 1, c);
        lx_err = 1;
      end
    end
  endfunction

  function automatic void close_number(logic [7:0] c, int unsigned p);
    flush_held();
    if (c_alpha(c)) begin
      push_tok(K_ERR, 0, p, 1, c);
      lx_err = 1;
    end else begin
      begin_token(c, p);
    end
  endfunction

  function automatic void scan_char(logic [7:0] c, int unsigned p);
    int h;
    string kt, kf;
    kt = "true"; kf = "false";
    h = c_hexval(c);
    case (lx_mode)
      S_IDENT:
        if (c_alpha(c) || c_digit(c) || c == "." || c == "_" || c == "/") begin
          if (!(lx_len < 4 && c == kt[lx_len])) lx_kw[0] = 0;
          if (!(lx_len < 5 && c == kf[lx_len])) lx_kw[1] = 0;
          bump_len();
        end else begin
          flush_held(); begin_token(c, p);
        end
      S_ZERO:
        if (c == "x" || c == "X") begin
          lx_mode = S_HEXPFX; lx_xch = c; bump_len();
        end else if (c == "b") begin
          lx_mode = S_BINPFX; bump_len();
        end else if (c >= "0" && c <= "7") begin
          lx_mode = S_OCT; add_digit(8, c - "0"); bump_len();
        end else close_number(c, p);
      S_DEC:
        if (c_digit(c)) begin add_digit(10, c - "0"); bump_len(); end
        else close_number(c, p);
      S_OCT:
        if (c >= "0" && c <= "7") begin add_digit(8, c - "0"); bump_len(); end
        else close_number(c, p);
      S_HEXPFX:
        if (h >= 0) begin lx_mode = S_HEX; lx_acc = h; bump_len(); end
        else flush_held();
      S_HEX:
        if (h >= 0) begin add_digit(16, h); bump_len(); end
        else close_number(c, p);
      S_BINPFX, S_BIN:
        if (c == "0" || c == "1") begin
          lx_mode = S_BIN; add_digit(2, c - "0"); bump_len();
        end else close_number(c, p);
      S_OP:
        if (c == "=") begin
          push_tok(K_OP, lx_op + 4, lx_start, 2, 0); clear_scan();
        end else begin
          flush_held(); begin_token(c, p);
        end
      default: begin_token(c, p);
    endcase
  endfunction

  // expected tokens for one accepted request
  function automatic void predict_tokens(char_req_t r);
    int unsigned p;
    step_toks.delete();
    p = lx_pos % MAXC;
    if (r.eos) begin
      if (!lx_err) begin
        flush_held();
        if (!lx_err) push_tok(K_END, 0, p, 0, 0);
      end else begin
        push_tok(K_END, 0, p, 0, 0);
      end
      reset_scan();
    end else if (!lx_err) begin
      scan_char(r.ch, p);
      lx_pos = (p + 1) % MAXC;
      if (lx_err) clear_scan();
    end
    if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last = 1'b1;
    foreach (step_toks[i]) expected_tokens.push_back(step_toks[i]);
  endfunction

  // stimulus helpers
  function automatic void put_str(string s);
    char_req_t r;
    for (int i = 0; i < s.len(); i++) begin
      r.ch = s[i]; r.eos = 0; pending_chars.push_back(r);
    end
  endfunction

  function automatic void put_end();
    char_req_t r;
    r.ch = $urandom_range(0, 255); r.eos = 1; pending_chars.push_back(r);
  endfunction

  function automatic void put_byte(logic [7:0] c);
    char_req_t r;
    r.ch = c; r.eos = 0; pending_chars.push_back(r);
  endfunction

  function automatic string rand_word();
    string pool[] = '{"true", "false", "tru", "truex", "falsey", "x_1", ".a/b", "_T9",
                      "Zq", "f", "t"};
    string alnum = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789._/";
    string s;
    if ($urandom_range(0, 1)) return pool[$urandom_range(0, pool.size() - 1)];
    s = "a";
    s[0] = alnum[$urandom_range(0, 53)];
    repeat ($urandom_range(0, 6)) s = {s, "a"};
    for (int i = 1; i < s.len(); i++) s[i] = alnum[$urandom_range(0, alnum.len() - 1)];
    return s;
  endfunction

  function automatic string rand_number();
    string dec = "0123456789", hx = "0123456789abcdefABCDEF";
    string s;
    int n;
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 24) : $urandom_range(1, 5);
    case ($urandom_range(0, 3))
      0: begin s = "1"; s[0] = dec[$urandom_range(1, 9)];
         repeat (n) begin s = {s, "0"}; s[s.len() - 1] = dec[$urandom_range(0, 9)]; end end
      1: begin s = $urandom_range(0, 1) ? "0x" : "0X";
         repeat (n) begin s = {s, "0"}; s[s.len() - 1] = hx[$urandom_range(0, 21)]; end end
      2: begin s = "0";
         repeat (n) begin s = {s, "0"}; s[s.len() - 1] = dec[$urandom_range(0, 9)]; end end
      default: begin s = "0b";
         repeat (n * 3) begin s = {s, "0"}; s[s.len() - 1] = dec[$urandom_range(0, 1)]; end end
    endcase
    return s;
  endfunction

  function automatic string rand_sep();
    string seps[] = '{"+", "-", "*", "/", "+=", "-=", "*=", "/=", "=", "(", ")", " ",
                      "\t", "\n", "\r", " ( ", ") "};
    return seps[$urandom_range(0, seps.size() - 1)];
  endfunction

  // queue stimulus: directed expressions, then random well-formed lines with noise
  initial begin
    string directed[] = '{
      "a1 = b.c_d/e + 42;",
      "true false tru truex falsey",
      "0x1F*0XaB-017/0b101",
      "0 09 0b2 0b 0x",
      "0xg",
      "12abc",
      "18446744073709551615 18446744073709551616 0xFFFFFFFFFFFFFFFFF1",
      "+= -= *= /= = ( ) \t\r\n",
      "x+ y- z* w/ q",
      "7@8",
      "0x"
    };
    foreach (directed[i]) begin
      put_str(directed[i]); put_end();
    end
    put_byte(8'h00); put_end();
    put_byte(8'hFF); put_byte(8'h80); put_end();
    put_end();
    while (pending_chars.size() < 1090) begin
      int n;
      n = $urandom_range(1, 8);
      for (int t = 0; t < n; t++) begin
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 8) put_str(rand_word());
        else if (pick < 16) put_str(rand_number());
        else if (pick < 19) put_str(rand_sep());
        else put_byte($urandom_range(0, 255));
        put_str(rand_sep());
      end
      put_end();
    end
    stim_done = 1'b1;
  end

  // remember whether the request on the bus was taken at this edge
  always @(posedge clk) in_hs <= rst_n && in_tvalid && in_tready;

  // sender: bursts with gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_tvalid && !in_hs) begin
        // hold the request
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_tvalid <= 1'b0;
      end else if (pending_chars.size() > 0) begin
        char_req_t r;
        r = pending_chars.pop_front();
        in_tdata <= r.ch;
        in_tlast <= r.eos;
        in_tvalid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern with calm stretches
  int rx_phase = 0;
  always @(negedge clk) begin
    rx_phase <= rx_phase + 1;
    if ((rx_phase / 300) % 3 == 0) out_tready <= 1'b1;
    else out_tready <= ($urandom_range(0, 3) != 0);
  end

  // predict on accepted requests, check accepted tokens
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      char_req_t r;
      r.ch = in_tdata; r.eos = in_tlast;
      predict_tokens(r);
    end
    if (rst_n && out_tvalid && out_tready) begin
      tok_t want;
      tokens_seen++;
      if (expected_tokens.size() == 0) begin
        errors++;
        $display("%0t: unexpected token kind %0d value %h", $time, out_tuser, out_tdata[63:0]);
      end else begin
        want = expected_tokens.pop_front();
        if (out_tuser !== want.kind || out_tdata[63:0] !== want.value ||
            out_tdata[75:64] !== want.start || out_tdata[88:76] !== want.length ||
            out_tdata[96:89] !== want.bad || out_tdata[103:97] !== 7'd0 ||
            out_tlast !== want.last) begin
          errors++;
          $display("%0t: expected kind %0d value %h start %0d len %0d bad %h last %b", $time,
                   want.kind, want.value, want.start, want.length, want.bad, want.last);
          $display("%0t: actual   kind %0d value %h start %0d len %0d bad %h last %b", $time,
                   out_tuser, out_tdata[63:0], out_tdata[75:64], out_tdata[88:76],
                   out_tdata[96:89], out_tlast);
        end
      end
    end
  end

  // reset, then wait for the drain
  initial begin
    reset_scan();
    repeat (8) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    wait (stim_done && pending_chars.size() == 0);
    @(posedge clk);
    while (in_tvalid || expected_tokens.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Covered %0d tokens from directed and random expressions, incl. errors,", tokens_seen);
    $display("saturating literals, keywords, operators and number prefixes.");
    if (errors == 0 && expected_tokens.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
